>>> design/cron_field_validator_defines.svh
// ----------------------------------------------------------------------------
// Cron field validator assertion macros
// Shared property forms used by the checker of the cron field validator.
// ----------------------------------------------------------------------------
`ifndef CRON_FIELD_VALIDATOR_DEFINES_SVH
`define CRON_FIELD_VALIDATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CFV_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cron_field_validator assertion failed");

// Next-cycle implication, disabled during reset.
`define CFV_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cron_field_validator assertion failed");

// Next-cycle implication that is also checked during reset.
`define CFV_ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("cron_field_validator assertion failed");

`endif

>>> design/cfv_pkg.sv
// ----------------------------------------------------------------------------
// Cron field validator package
// Token kinds, character codes, field limits and shared types.
// ----------------------------------------------------------------------------
package cfv_pkg;

  localparam int unsigned NUM_FIELDS = 5;
  localparam int unsigned FIELD_IDX_W = 3;
  localparam int unsigned VALUE_W = 8;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_STAR = 8'h2a;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [VALUE_W-1:0] VALUE_CAP = 8'd255;

  typedef enum logic [1:0] {
    KIND_EMPTY,
    KIND_STAR,
    KIND_NUM,
    KIND_OTHER
  } kind_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       last_char;
  } cfv_item_t;

  // Inclusive lower bound of each field.
  function automatic logic [VALUE_W-1:0] field_lo(input logic [FIELD_IDX_W-1:0] idx);
    logic [VALUE_W-1:0] lo;
    case (idx)
      3'd2: lo = 8'd1;
      3'd3: lo = 8'd1;
      default: lo = 8'd0;
    endcase
    return lo;
  endfunction

  // Exclusive upper bound of each field.
  function automatic logic [VALUE_W-1:0] field_limit(input logic [FIELD_IDX_W-1:0] idx);
    logic [VALUE_W-1:0] lim;
    case (idx)
      3'd0: lim = 8'd60;
      3'd1: lim = 8'd24;
      3'd2: lim = 8'd32;
      3'd3: lim = 8'd13;
      3'd4: lim = 8'd8;
      default: lim = 8'd0;
    endcase
    return lim;
  endfunction

endpackage

>>> design/cron_field_validator.sv
// ----------------------------------------------------------------------------
// Cron field validator
// Checks a cron schedule string that arrives one byte per transaction.
// ----------------------------------------------------------------------------
// The char channel (char_valid, char_stall, char_byte, last_char) carries the
// string, one byte per transaction; last_char marks its final byte. Spaces
// separate tokens. The result channel (result_valid, result_stall, is_valid)
// carries one transaction per string, is_valid high when the first five
// tokens are each a star or a number within its field's range.
// A byte is registered on acceptance and then updates the parser state; the
// result goes to the output register with the last byte's update. One byte
// is taken every cycle while char_stall is low; the rate is set by the
// single parser state update per byte.
// Reset clears the parser state and empties both pipeline registers. When
// the receiver stalls, the result is held; bytes keep flowing until a second
// last byte needs the held output register, and then char_stall rises.
// ----------------------------------------------------------------------------
module cron_field_validator (
  input  logic       clk,
  input  logic       rst,
  input  logic       char_valid,
  output logic       char_stall,
  input  logic [7:0] char_byte,
  input  logic       last_char,
  output logic       result_valid,
  input  logic       result_stall,
  output logic       is_valid
);

  logic               s1_valid;
  cfv_pkg::cfv_item_t s1_item;
  logic               out_free;
  logic               s1_fire;
  logic               s1_load;
  logic               pass;

  assign out_free = !result_valid || !result_stall;
  assign s1_fire = s1_valid && (!s1_item.last_char || out_free);
  assign char_stall = s1_valid && !s1_fire;
  assign s1_load = char_valid && !char_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_item.char_byte <= char_byte;
      s1_item.last_char <= last_char;
    end
  end

  cfv_parser u_parser (
    .clk  (clk),
    .rst  (rst),
    .step (s1_fire),
    .item (s1_item),
    .pass (pass)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_fire && s1_item.last_char) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_item.last_char) begin
      is_valid <= pass;
    end
  end

endmodule

>>> design/cfv_parser.sv
// ----------------------------------------------------------------------------
// Cron field parser
// Holds the token state and scores the first five fields, one byte per step.
// ----------------------------------------------------------------------------
module cfv_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  cfv_pkg::cfv_item_t item,
  output logic              pass
);

  cfv_pkg::kind_t                    kind, kind_next;
  logic [cfv_pkg::VALUE_W-1:0]       value, value_next;
  logic [cfv_pkg::FIELD_IDX_W-1:0]   field_index, field_index_next;
  logic [cfv_pkg::FIELD_IDX_W-1:0]   good_fields, good_fields_next;

  logic                              is_space;
  logic                              is_digit;
  logic [3:0]                        digit;
  logic [11:0]                       acc;
  cfv_pkg::kind_t                    kind_take;
  logic [cfv_pkg::VALUE_W-1:0]       value_take;
  cfv_pkg::kind_t                    kind_pre;
  logic [cfv_pkg::VALUE_W-1:0]       value_pre;
  logic                              do_close;
  logic                              counts;
  logic                              ok;
  logic [cfv_pkg::FIELD_IDX_W-1:0]   fi_closed;
  logic [cfv_pkg::FIELD_IDX_W-1:0]   good_closed;
  logic [7:0]                        digit_wide;

  always_comb begin
    is_space = (item.char_byte == cfv_pkg::CHAR_SPACE);
    is_digit = (item.char_byte >= cfv_pkg::CHAR_ZERO) && (item.char_byte <= cfv_pkg::CHAR_NINE);
    digit_wide = item.char_byte - cfv_pkg::CHAR_ZERO;
    digit = digit_wide[3:0];
    acc = {1'b0, value, 3'b000} + {3'b000, value, 1'b0} + {8'd0, digit};

    kind_take = cfv_pkg::KIND_OTHER;
    value_take = value;
    case (kind)
      cfv_pkg::KIND_EMPTY: begin
        value_take = '0;
        if (item.char_byte == cfv_pkg::CHAR_STAR) begin
          kind_take = cfv_pkg::KIND_STAR;
        end else if (is_digit) begin
          kind_take = cfv_pkg::KIND_NUM;
          value_take = {4'd0, digit};
        end
      end
      cfv_pkg::KIND_NUM: begin
        if (is_digit) begin
          kind_take = cfv_pkg::KIND_NUM;
          value_take = (acc > {4'd0, cfv_pkg::VALUE_CAP}) ? cfv_pkg::VALUE_CAP : acc[7:0];
        end
      end
      default: kind_take = cfv_pkg::KIND_OTHER;
    endcase

    kind_pre = is_space ? kind : kind_take;
    value_pre = is_space ? value : value_take;
    do_close = is_space || item.last_char;
    counts = (kind_pre != cfv_pkg::KIND_EMPTY) &&
             (field_index < cfv_pkg::FIELD_IDX_W'(cfv_pkg::NUM_FIELDS));

    case (kind_pre)
      cfv_pkg::KIND_STAR: ok = 1'b1;
      cfv_pkg::KIND_NUM: ok = (value_pre >= cfv_pkg::field_lo(field_index)) &&
                              (value_pre < cfv_pkg::field_limit(field_index));
      default: ok = 1'b0;
    endcase

    fi_closed = counts ? field_index + 3'd1 : field_index;
    good_closed = (counts && ok) ? good_fields + 3'd1 : good_fields;
    pass = (good_closed == cfv_pkg::FIELD_IDX_W'(cfv_pkg::NUM_FIELDS));

    if (item.last_char) begin
      kind_next = cfv_pkg::KIND_EMPTY;
      value_next = '0;
      field_index_next = '0;
      good_fields_next = '0;
    end else if (do_close) begin
      kind_next = cfv_pkg::KIND_EMPTY;
      value_next = '0;
      field_index_next = fi_closed;
      good_fields_next = good_closed;
    end else begin
      kind_next = kind_take;
      value_next = value_take;
      field_index_next = field_index;
      good_fields_next = good_fields;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kind <= cfv_pkg::KIND_EMPTY;
      value <= '0;
      field_index <= '0;
      good_fields <= '0;
    end else if (step) begin
      kind <= kind_next;
      value <= value_next;
      field_index <= field_index_next;
      good_fields <= good_fields_next;
    end
  end

endmodule

>>> design/cfv_checker.sv
// ----------------------------------------------------------------------------
// Cron field validator checker
// Port-level properties of the validator, bound to its top level.
// ----------------------------------------------------------------------------
`include "cron_field_validator_defines.svh"

module cfv_checker (
  input logic       clk,
  input logic       rst,
  input logic       char_valid,
  input logic       char_stall,
  input logic [7:0] char_byte,
  input logic       last_char,
  input logic       result_valid,
  input logic       result_stall,
  input logic       is_valid
);

  logic unused_ok;
  assign unused_ok = ^{char_valid, char_byte, last_char};

  `CFV_ASSERT_NEXT(a_result_holds, clk, rst, result_valid && result_stall, result_valid && $stable(is_valid))
  `CFV_ASSERT_SAME(a_stall_only_on_held_result, clk, rst, char_stall, result_valid && result_stall)
  `CFV_ASSERT_ALWAYS(a_empty_after_reset, clk, rst, !result_valid && !char_stall)

endmodule

bind cron_field_validator cfv_checker u_cfv_checker (
  .clk          (clk),
  .rst          (rst),
  .char_valid   (char_valid),
  .char_stall   (char_stall),
  .char_byte    (char_byte),
  .last_char    (last_char),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .is_valid     (is_valid)
);
